// File: rtl/sed_pkg.sv
// Shared types, character codes and helper functions for the string escape decoder.
// No dependencies; used by sed_step and string_escape_decoder.
`timescale 1ns / 1ps

package sed_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = 3;   // holds 0 .. MaxResults
   localparam int IndexWidth = 2;   // addresses MaxResults entries

   // escape_mode codes
   localparam logic [2:0] ModeText      = 3'd0;
   localparam logic [2:0] ModeBackslash = 3'd1;
   localparam logic [2:0] ModeByteHex   = 3'd2;
   localparam logic [2:0] ModeUniHex    = 3'd3;

   // error codes
   localparam logic [1:0] ErrNone       = 2'd0;
   localparam logic [1:0] ErrBadDigit   = 2'd1;
   localparam logic [1:0] ErrIncomplete = 2'd2;

   // character codes
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChZero      = 8'h30;
   localparam logic [7:0] ChA         = 8'h61;
   localparam logic [7:0] ChB         = 8'h62;
   localparam logic [7:0] ChF         = 8'h66;
   localparam logic [7:0] ChN         = 8'h6E;
   localparam logic [7:0] ChR         = 8'h72;
   localparam logic [7:0] ChT         = 8'h74;
   localparam logic [7:0] ChV         = 8'h76;
   localparam logic [7:0] ChX         = 8'h78;
   localparam logic [7:0] ChLowU      = 8'h75;
   localparam logic [7:0] ChUpU       = 8'h55;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic [1:0] err;
   } entry_type;

   // All results caused by one input item.
   typedef struct packed {
      logic [CountWidth-1:0]            count;
      logic                             last;
      entry_type [MaxResults-1:0]       entry;
   } step_type;

   // Hex digit value: bit 4 set when the character is a valid digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// File: rtl/string_escape_decoder.sv
// Top level of the string escape decoder: input register, result buffer and handshakes.
// Depends on sed_pkg and sed_step.
`timescale 1ns / 1ps

// The block takes the body of a quoted string literal one character per transfer on the
// req_ channel (req_is_last marks the final character) and delivers the decoded string on
// the rsp_ channel, one byte or status per transfer. Escapes such as \n, \x41, \u00e9 and
// \U0001F600 are resolved, the Unicode forms expanded to one to four UTF-8 bytes. Bad hex
// digits and escapes cut off by the end are reported through rsp_error_code with
// rsp_byte_valid low. rsp_last_of_run marks the final result caused by a character and
// rsp_end_of_string the final result of the literal. Characters inside an escape usually
// produce no result at all. Rate: one character per cycle while rsp_ready stays high and each
// character yields at most one result; a character that yields several results holds the input
// until the result buffer has handed all of them out, as a \u or \U escape ending in a multi-byte
// code point does. A req_ character passes through the input register, then the result buffer.
module string_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_string,
   output logic [1:0] rsp_error_code
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // result buffer: every result of one character, handed out in order
   sed_pkg::entry_type [sed_pkg::MaxResults-1:0] buf_ff;
   logic [sed_pkg::CountWidth-1:0] buf_count_ff;
   logic [sed_pkg::IndexWidth-1:0] buf_idx_ff;
   logic                           buf_last_ff;

   sed_pkg::step_type step;
   logic rsp_take;
   logic final_take;
   logic buf_free;
   logic step_fire;
   logic at_final;

   // decode the held character into the result buffer once the buffer drains
   sed_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .char_in (in_char_ff),
      .is_last (in_last_ff),
      .step    (step)
   );

   assign at_final   = ({1'b0, buf_idx_ff} == buf_count_ff - 3'd1);
   assign rsp_take   = rsp_valid && rsp_ready;
   assign final_take = rsp_take && at_final;
   // buffer is free when empty, or when its final result leaves in this cycle
   assign buf_free   = (buf_count_ff == '0) || final_take;
   assign step_fire  = in_valid_ff && buf_free;
   assign req_ready  = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload: hold while stalled, load on every free cycle
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_count_ff <= '0;
         buf_idx_ff   <= '0;
      end else if (step_fire) begin
         buf_count_ff <= step.count;
         buf_idx_ff   <= '0;
      end else if (final_take) begin
         buf_count_ff <= '0;
         buf_idx_ff   <= '0;
      end else if (rsp_take) begin
         buf_idx_ff   <= buf_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         buf_ff      <= step.entry;
         buf_last_ff <= step.last;
      end
   end

   // present the current buffer entry
   assign rsp_valid         = (buf_count_ff != '0);
   assign rsp_out_byte      = buf_ff[buf_idx_ff].data;
   assign rsp_byte_valid    = buf_ff[buf_idx_ff].valid;
   assign rsp_error_code    = buf_ff[buf_idx_ff].err;
   assign rsp_last_of_run   = at_final;
   assign rsp_end_of_string = at_final && buf_last_ff;

   // buffer never claims more results than one character can cause
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      buf_count_ff <= 3'(sed_pkg::MaxResults))
      else $error("result buffer count out of range");

   // read index stays within the filled part of the buffer
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, buf_idx_ff} < buf_count_ff))
      else $error("result index beyond buffer fill");

   // a decode loads the buffer with exactly its result count
   a_load: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (buf_count_ff == $past(step.count)) && (buf_idx_ff == '0))
      else $error("result buffer not loaded on decode");

   // a literal end always yields a result, so an end never vanishes
   a_end_seen: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_last_ff) |=> rsp_valid)
      else $error("end of literal produced no result");

   // a stalled input keeps its character
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_fire) |=> in_valid_ff && $stable(in_char_ff))
      else $error("held character lost while stalled");

endmodule

// File: rtl/sed_step.sv
// Escape state and single-item decode: turns one body character into up to four results.
// Depends on sed_pkg.
`timescale 1ns / 1ps

module sed_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        char_in,
   input  logic              is_last,
   output sed_pkg::step_type step
);

   logic [2:0]  mode_ff,  mode_in;
   logic [3:0]  left_ff,  left_in;
   logic [31:0] acc_ff,   acc_in;
   logic        derr_ff,  derr_in;

   always_comb begin
      logic [4:0]  hv;
      logic [31:0] cp;
      logic [7:0]  bytes [sed_pkg::MaxResults];
      logic [2:0]  nbytes;
      logic [1:0]  err;
      logic [2:0]  n;

      mode_in = mode_ff;
      left_in = left_ff;
      acc_in  = acc_ff;
      derr_in = derr_ff;
      nbytes  = 3'd0;
      err     = sed_pkg::ErrNone;
      cp      = 32'd0;
      hv      = sed_pkg::hex_value(char_in);
      for (int i = 0; i < sed_pkg::MaxResults; i++) bytes[i] = 8'd0;

      case (mode_ff)
         sed_pkg::ModeBackslash: begin
            mode_in  = sed_pkg::ModeText;
            nbytes   = 3'd1;
            bytes[0] = char_in;
            case (char_in)
               sed_pkg::ChZero: bytes[0] = 8'h00;
               sed_pkg::ChA:    bytes[0] = 8'h07;
               sed_pkg::ChB:    bytes[0] = 8'h08;
               sed_pkg::ChF:    bytes[0] = 8'h0C;
               sed_pkg::ChN:    bytes[0] = 8'h0A;
               sed_pkg::ChR:    bytes[0] = 8'h0D;
               sed_pkg::ChT:    bytes[0] = 8'h09;
               sed_pkg::ChV:    bytes[0] = 8'h0B;
               sed_pkg::ChX: begin
                  nbytes = 3'd0; mode_in = sed_pkg::ModeByteHex;
                  left_in = 4'd2; acc_in = 32'd0; derr_in = 1'b0;
               end
               sed_pkg::ChLowU: begin
                  nbytes = 3'd0; mode_in = sed_pkg::ModeUniHex;
                  left_in = 4'd4; acc_in = 32'd0; derr_in = 1'b0;
               end
               sed_pkg::ChUpU: begin
                  nbytes = 3'd0; mode_in = sed_pkg::ModeUniHex;
                  left_in = 4'd8; acc_in = 32'd0; derr_in = 1'b0;
               end
               default: bytes[0] = char_in;
            endcase
         end
         sed_pkg::ModeByteHex, sed_pkg::ModeUniHex: begin
            derr_in = derr_ff | ~hv[4];
            acc_in  = {acc_ff[27:0], (hv[4] ? hv[3:0] : 4'd0)};
            left_in = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
            if (left_in == 4'd0) begin
               cp = acc_in;
               if (derr_in) begin
                  err = sed_pkg::ErrBadDigit;
               end else if (mode_ff == sed_pkg::ModeByteHex) begin
                  nbytes   = 3'd1;
                  bytes[0] = acc_in[7:0];
               end else if (cp < 32'h80) begin
                  nbytes   = 3'd1;
                  bytes[0] = cp[7:0];
               end else if (cp < 32'h800) begin
                  nbytes   = 3'd2;
                  bytes[0] = {3'b110, cp[10:6]};
                  bytes[1] = {2'b10, cp[5:0]};
               end else if (cp < 32'h10000) begin
                  nbytes   = 3'd3;
                  bytes[0] = {4'b1110, cp[15:12]};
                  bytes[1] = {2'b10, cp[11:6]};
                  bytes[2] = {2'b10, cp[5:0]};
               end else if (cp <= 32'h10FFFF) begin
                  nbytes   = 3'd4;
                  bytes[0] = {5'b11110, cp[20:18]};
                  bytes[1] = {2'b10, cp[17:12]};
                  bytes[2] = {2'b10, cp[11:6]};
                  bytes[3] = {2'b10, cp[5:0]};
               end
               mode_in = sed_pkg::ModeText;
               acc_in  = 32'd0;
               derr_in = 1'b0;
            end
         end
         default: begin
            if (char_in == sed_pkg::ChBackslash) begin
               mode_in = sed_pkg::ModeBackslash;
            end else begin
               nbytes   = 3'd1;
               bytes[0] = char_in;
            end
         end
      endcase

      // end of literal: flag an escape left open, then drop all escape state
      if (is_last && mode_in != sed_pkg::ModeText) err = sed_pkg::ErrIncomplete;
      if (is_last) begin
         mode_in = sed_pkg::ModeText;
         left_in = 4'd0;
         acc_in  = 32'd0;
         derr_in = 1'b0;
      end

      // entries without a decoded byte carry a zero byte
      for (int i = 0; i < sed_pkg::MaxResults; i++) begin
         step.entry[i].data  = (3'(i) < nbytes) ? bytes[i] : 8'd0;
         step.entry[i].valid = (3'(i) < nbytes);
         step.entry[i].err   = sed_pkg::ErrNone;
      end
      n = nbytes;
      // error and empty-end results never coexist with emitted bytes
      if (err != sed_pkg::ErrNone) begin
         step.entry[0].err = err;
         n = 3'd1;
      end else if (is_last && nbytes == 3'd0) begin
         n = 3'd1;
      end
      step.count = n;
      step.last  = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sed_pkg::ModeText;
         left_ff <= 4'd0;
         acc_ff  <= 32'd0;
         derr_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         acc_ff  <= acc_in;
         derr_ff <= derr_in;
      end
   end

endmodule
